// ===== rtl/core/pfs_pkg.sv =====
// Shared types, codes and helpers for the printf format directive parser.
// No dependencies; used by every module under rtl/core.
package pfs_pkg;

  localparam int unsigned DefNumBits = 32;

  // Parse phases (plain vector codes)
  localparam logic [2:0] PhFlags  = 3'd0;
  localparam logic [2:0] PhWdig   = 3'd1;
  localparam logic [2:0] PhAftw   = 3'd2;
  localparam logic [2:0] PhAftdot = 3'd3;
  localparam logic [2:0] PhPdig   = 3'd4;
  localparam logic [2:0] PhType   = 3'd5;
  localparam logic [2:0] PhDone   = 3'd6;
  localparam logic [2:0] PhErr    = 3'd7;

  // Result status codes
  localparam logic [1:0] StOpen = 2'd0;
  localparam logic [1:0] StDone = 2'd1;
  localparam logic [1:0] StErr  = 2'd2;

  // Characters
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChDot   = 8'h2E;

  localparam int unsigned NumConv = 9;
  localparam logic [7:0] ConvSet [NumConv] = '{
    8'h63, 8'h73, 8'h70, 8'h64, 8'h69, 8'h75, 8'h78, 8'h58, 8'h25
  };

  typedef struct packed {
    logic [2:0]         phase;
    logic               left;
    logic               zero;
    logic               plus;
    logic               space;
    logic               alt;
    logic               dot;
    logic [30:0]        width;
    logic signed [31:0] prec;
    logic [7:0]         conv;
  } pfs_state_t;

  localparam pfs_state_t StateRst = '{
    phase: PhFlags, left: 1'b0, zero: 1'b0, plus: 1'b0, space: 1'b0,
    alt: 1'b0, dot: 1'b0, width: '0, prec: '0, conv: '0
  };

  // Saturation limit 2^(nb-1)-1, capped at 2^31-1
  function automatic logic [30:0] lim_of(int unsigned nb);
    logic [63:0] one;
    one = 64'd1;
    if (nb >= 32) begin
      return '1;
    end
    return 31'((one << (nb - 1)) - one);
  endfunction

  function automatic logic is_conv(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumConv; k++) begin
      if (ConvSet[k] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [1:0] status_of(logic [2:0] ph);
    if (ph == PhDone) return StDone;
    if (ph == PhErr) return StErr;
    return StOpen;
  endfunction

endpackage

// ===== rtl/core/pfs_dec_acc.sv =====
// Saturating decimal accumulator: acc*10 + digit, clipped at the limit.
// Depends on pfs_pkg.
module pfs_dec_acc #(
  parameter int unsigned NumBits = pfs_pkg::DefNumBits
) (
  input  logic [30:0] acc_i,
  input  logic [3:0]  digit_i,
  output logic [30:0] acc_o
);

  localparam logic [30:0] Lim = pfs_pkg::lim_of(NumBits);

  logic [34:0] prod;

  // x10 as shift-add
  assign prod  = ({4'd0, acc_i} << 3) + ({4'd0, acc_i} << 1) + {31'd0, digit_i};
  assign acc_o = (prod > {4'd0, Lim}) ? Lim : prod[30:0];

endmodule

// ===== rtl/core/pfs_step.sv =====
// One-character update of the directive state, including phase fall-through.
// Depends on pfs_pkg and pfs_dec_acc.
module pfs_step #(
  parameter int unsigned NumBits = pfs_pkg::DefNumBits
) (
  input  pfs_pkg::pfs_state_t state_i,
  input  logic                cmd_i,
  input  logic [7:0]          ch_i,
  input  logic signed [31:0]  arg_i,
  output pfs_pkg::pfs_state_t state_o,
  output logic                used_o
);

  localparam logic [30:0] Lim = pfs_pkg::lim_of(NumBits);
  localparam logic signed [32:0] LimS = $signed({2'b00, Lim});
  localparam logic signed [32:0] LoS  = -LimS - 33'sd1;

  pfs_pkg::pfs_state_t cur;
  logic [30:0] wid_dig;
  logic [30:0] prec_dig;
  logic        is_dig;
  logic [31:0] mag;
  logic [30:0] mag_sat;
  logic signed [32:0] arg_x;
  logic signed [31:0] prec_clamp;

  assign cur    = cmd_i ? pfs_pkg::StateRst : state_i;
  assign is_dig = (ch_i >= pfs_pkg::ChZero) && (ch_i <= pfs_pkg::ChNine);

  pfs_dec_acc #(.NumBits(NumBits)) u_wid_acc (
    .acc_i  (cur.width),
    .digit_i(ch_i[3:0]),
    .acc_o  (wid_dig)
  );

  // precision is never negative while digits are taken
  pfs_dec_acc #(.NumBits(NumBits)) u_prec_acc (
    .acc_i  (cur.prec[30:0]),
    .digit_i(ch_i[3:0]),
    .acc_o  (prec_dig)
  );

  // star width magnitude, most negative value saturates
  assign mag     = arg_i[31] ? (~arg_i + 32'd1) : arg_i;
  assign mag_sat = (mag > {1'b0, Lim}) ? Lim : mag[30:0];

  assign arg_x = {arg_i[31], arg_i};
  always_comb begin
    if (arg_x > LimS) begin
      prec_clamp = LimS[31:0];
    end else if (arg_x < LoS) begin
      prec_clamp = LoS[31:0];
    end else begin
      prec_clamp = arg_i;
    end
  end

  always_comb begin
    logic stop;
    stop    = 1'b0;
    state_o = cur;
    used_o  = 1'b0;
    if (cur.phase != pfs_pkg::PhDone && cur.phase != pfs_pkg::PhErr) begin
      if (state_o.phase == pfs_pkg::PhFlags) begin
        stop   = 1'b1;
        used_o = 1'b1;
        if (ch_i == pfs_pkg::ChMinus) begin
          state_o.left = 1'b1;
          state_o.zero = 1'b0;
        end else if (ch_i == pfs_pkg::ChZero) begin
          if (!state_o.left) state_o.zero = 1'b1;
        end else if (ch_i == pfs_pkg::ChPlus) begin
          state_o.plus = 1'b1;
        end else if (ch_i == pfs_pkg::ChSpace) begin
          state_o.space = 1'b1;
        end else if (ch_i == pfs_pkg::ChHash) begin
          state_o.alt = 1'b1;
        end else if (ch_i == pfs_pkg::ChStar) begin
          if (arg_i[31]) state_o.left = 1'b1;
          state_o.width = mag_sat;
          state_o.phase = pfs_pkg::PhAftw;
        end else begin
          stop          = 1'b0;
          used_o        = 1'b0;
          state_o.phase = pfs_pkg::PhWdig;
        end
      end
      if (!stop && state_o.phase == pfs_pkg::PhWdig) begin
        if (is_dig) begin
          state_o.width = wid_dig;
          stop          = 1'b1;
          used_o        = 1'b1;
        end else begin
          state_o.phase = pfs_pkg::PhAftw;
        end
      end
      if (!stop && state_o.phase == pfs_pkg::PhAftw) begin
        if (ch_i == pfs_pkg::ChDot) begin
          state_o.dot   = 1'b1;
          state_o.prec  = '0;
          state_o.phase = pfs_pkg::PhAftdot;
          stop          = 1'b1;
          used_o        = 1'b1;
        end else begin
          state_o.phase = pfs_pkg::PhType;
        end
      end
      if (!stop && state_o.phase == pfs_pkg::PhAftdot) begin
        if (ch_i == pfs_pkg::ChStar) begin
          state_o.prec  = prec_clamp;
          if (prec_clamp[31]) state_o.dot = 1'b0;
          state_o.phase = pfs_pkg::PhType;
          stop          = 1'b1;
          used_o        = 1'b1;
        end else begin
          state_o.phase = pfs_pkg::PhPdig;
        end
      end
      if (!stop && state_o.phase == pfs_pkg::PhPdig) begin
        if (is_dig) begin
          state_o.prec = $signed({1'b0, prec_dig});
          stop         = 1'b1;
          used_o       = 1'b1;
        end else begin
          state_o.phase = pfs_pkg::PhType;
        end
      end
      if (!stop) begin
        if (pfs_pkg::is_conv(ch_i)) begin
          state_o.conv  = ch_i;
          state_o.phase = pfs_pkg::PhDone;
          used_o        = 1'b1;
        end else begin
          state_o.phase = pfs_pkg::PhErr;
        end
      end
    end
  end

endmodule

// ===== rtl/core/printf_format_spec_parser.sv =====
// printf format directive parser, top level: stream ports, input and result registers.
// Depends on pfs_pkg and pfs_step (which uses pfs_dec_acc).
//
// Feed the characters that follow a percent sign one item per cycle; set the
// command bit (tuser) on the first character of each directive to clear all
// gathered state. Every item yields exactly one result item carrying the
// status (open, done, error), whether the character was consumed, and the
// flags, width, precision and conversion gathered so far. An input passes
// through the input register, then the directive state register, whose
// content is the result. Throughput is one item per cycle while the
// receiver does not hold back the result; the state update between the
// input register and the directive state register is combinational. Width and
// precision digits saturate at 2^(NUM_BITS-1)-1, capped at 2^31-1. Characters
// after done or error are ignored (consumed = 0, all fields hold). An input
// item is taken while a result is still waiting, as long as the input
// register is free.
module printf_format_spec_parser #(
  parameter int unsigned NUM_BITS = pfs_pkg::DefNumBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [7:0] ch, [39:8] star_arg
  input  logic [0:0]  s_axis_tuser,  // [0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [0] consumed, [1] left_align, [2] zero_pad,
                                     // [3] plus_sign, [4] space_sign, [5] alt_form,
                                     // [6] has_dot, [37:7] field_width,
                                     // [69:38] prec_value, [77:70] conversion, [79:78] 0
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam logic [30:0] Lim = pfs_pkg::lim_of(NUM_BITS);

  // input register
  logic               in_vld_q;
  logic               in_cmd_q;
  logic [7:0]         in_ch_q;
  logic signed [31:0] in_arg_q;

  // directive state doubles as the result payload: it only moves when the
  // result slot is free, so it is stable while a result waits
  pfs_pkg::pfs_state_t st_q, st_d;
  logic                used_q, used_d;
  logic                out_vld_q;

  logic advance;
  logic in_take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= s_axis_tuser[0];
      in_ch_q  <= s_axis_tdata[7:0];
      in_arg_q <= $signed(s_axis_tdata[39:8]);
    end
  end

  pfs_step #(.NumBits(NUM_BITS)) u_step (
    .state_i(st_q),
    .cmd_i  (in_cmd_q),
    .ch_i   (in_ch_q),
    .arg_i  (in_arg_q),
    .state_o(st_d),
    .used_o (used_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= pfs_pkg::StateRst;
      used_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q      <= st_d;
        used_q    <= used_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = pfs_pkg::status_of(st_q.phase);
  assign m_axis_tdata  = {2'b00, st_q.conv, st_q.prec, st_q.width, st_q.dot,
                          st_q.alt, st_q.space, st_q.plus, st_q.zero, st_q.left, used_q};

  // a completed directive carries a conversion character
  a_done_has_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == pfs_pkg::PhDone) |-> (st_q.conv != 8'd0))
    else $error("done without conversion");

  // a result in the error phase (an erroring character or one ignored after it) is never reported as consumed
  a_err_not_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && st_q.phase == pfs_pkg::PhErr) |-> !used_q)
    else $error("consumed on error");

  // width never passes the saturation limit
  a_width_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.width <= Lim)
    else $error("width above limit");

endmodule

// ===== tb/sv/tb_printf_format_spec_parser.sv =====
// Self-checking testbench for printf_format_spec_parser: a directed table, then random
// well-formed and broken directives, each result checked against an in-bench predictor.
// Depends on pfs_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_printf_format_spec_parser;

  localparam int    CycleLimit = 400000;
  localparam int    HoldCycles = 300;
  // Decimal saturation bound for the default NUM_BITS of 32.
  localparam longint FieldLim  = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         status;
    logic               consumed;
    logic               left;
    logic               zero;
    logic               plus;
    logic               space;
    logic               alt;
    logic               dot;
    logic [30:0]        width;
    logic signed [31:0] prec;
    logic [7:0]         conv;
  } dir_result_t;

  typedef struct {
    logic               cmd;
    logic [7:0]         ch;
    logic signed [31:0] arg;
    bit                 typed;
    dir_result_t        want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Predictor state: phase plus the gathered fields (status/consumed unused here).
  logic [2:0]  st_phase = pfs_pkg::PhFlags;
  dir_result_t st = '0;

  dir_result_t directive_results_q[$];
  stim_row_t   directed_rows[$];

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit new_directive = 1'b0;
  int live_items = 0;
  int results_seen = 0;
  int done_seen = 0;
  int err_seen = 0;
  int sat_seen = 0;
  int fail_count = 0;
  int cycles = 0;

  printf_format_spec_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [30:0] sat_decimal(longint acc, logic [7:0] c);
    longint v;
    v = acc * 10 + (longint'(c) - longint'(pfs_pkg::ChZero));
    if (v > FieldLim) v = FieldLim;
    return v[30:0];
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return (c >= pfs_pkg::ChZero) && (c <= pfs_pkg::ChNine);
  endfunction

  // One item: a character falls through the phases until one takes it, or the
  // type check rejects it. Done and error phases swallow everything.
  function automatic dir_result_t predict_step(logic cmd, logic [7:0] c,
                                               logic signed [31:0] arg);
    logic        took;
    longint      mag;
    dir_result_t r;
    took = 1'b0;
    if (cmd) begin
      st_phase = pfs_pkg::PhFlags;
      st = '0;
    end
    if (st_phase != pfs_pkg::PhDone && st_phase != pfs_pkg::PhErr) begin
      if (st_phase == pfs_pkg::PhFlags) begin
        took = 1'b1;
        case (c)
          pfs_pkg::ChMinus: begin
            st.left = 1'b1;
            st.zero = 1'b0;
          end
          pfs_pkg::ChZero:  if (!st.left) st.zero = 1'b1;
          pfs_pkg::ChPlus:  st.plus = 1'b1;
          pfs_pkg::ChSpace: st.space = 1'b1;
          pfs_pkg::ChHash:  st.alt = 1'b1;
          pfs_pkg::ChStar: begin
            // negative star width: left align, magnitude (min int saturates)
            if (arg < 0) begin
              st.left = 1'b1;
              mag = -longint'(arg);
            end else begin
              mag = longint'(arg);
            end
            st.width = (mag > FieldLim) ? 31'(FieldLim) : mag[30:0];
            st_phase = pfs_pkg::PhAftw;
          end
          default: begin
            took = 1'b0;
            st_phase = pfs_pkg::PhWdig;
          end
        endcase
      end
      if (!took && st_phase == pfs_pkg::PhWdig) begin
        if (is_digit(c)) begin
          st.width = sat_decimal(longint'(st.width), c);
          took = 1'b1;
        end else begin
          st_phase = pfs_pkg::PhAftw;
        end
      end
      if (!took && st_phase == pfs_pkg::PhAftw) begin
        if (c == pfs_pkg::ChDot) begin
          st.dot = 1'b1;
          st.prec = '0;
          st_phase = pfs_pkg::PhAftdot;
          took = 1'b1;
        end else begin
          st_phase = pfs_pkg::PhType;
        end
      end
      if (!took && st_phase == pfs_pkg::PhAftdot) begin
        if (c == pfs_pkg::ChStar) begin
          // 32-bit argument always fits the clamp range; negative drops the dot
          st.prec = arg;
          if (arg < 0) st.dot = 1'b0;
          st_phase = pfs_pkg::PhType;
          took = 1'b1;
        end else begin
          st_phase = pfs_pkg::PhPdig;
        end
      end
      if (!took && st_phase == pfs_pkg::PhPdig) begin
        if (is_digit(c)) begin
          st.prec = {1'b0, sat_decimal(longint'(st.prec), c)};
          took = 1'b1;
        end else begin
          st_phase = pfs_pkg::PhType;
        end
      end
      if (!took) begin
        case (c)
          "c", "s", "p", "d", "i", "u", "x", "X", "%": begin
            st.conv = c;
            st_phase = pfs_pkg::PhDone;
            took = 1'b1;
          end
          default: st_phase = pfs_pkg::PhErr;
        endcase
      end
    end
    r = st;
    r.status = (st_phase == pfs_pkg::PhDone) ? pfs_pkg::StDone :
               (st_phase == pfs_pkg::PhErr) ? pfs_pkg::StErr : pfs_pkg::StOpen;
    r.consumed = took;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void cmp_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  dir_result_t got_r;
  dir_result_t want_r;

  // Sampled at the edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r.status   = m_axis_tuser;
      got_r.consumed = m_axis_tdata[0];
      got_r.left     = m_axis_tdata[1];
      got_r.zero     = m_axis_tdata[2];
      got_r.plus     = m_axis_tdata[3];
      got_r.space    = m_axis_tdata[4];
      got_r.alt      = m_axis_tdata[5];
      got_r.dot      = m_axis_tdata[6];
      got_r.width    = m_axis_tdata[37:7];
      got_r.prec     = m_axis_tdata[69:38];
      got_r.conv     = m_axis_tdata[77:70];
      results_seen++;
      if (got_r.status == pfs_pkg::StDone) done_seen++;
      if (got_r.status == pfs_pkg::StErr) err_seen++;
      if (longint'(got_r.width) == FieldLim) sat_seen++;
      if (directive_results_q.size() == 0) begin
        $error("result item with no expectation pending");
        fail_count++;
      end else begin
        want_r = directive_results_q.pop_front();
        cmp_field("status", want_r.status, got_r.status);
        cmp_field("consumed", want_r.consumed, got_r.consumed);
        cmp_field("left_align", want_r.left, got_r.left);
        cmp_field("zero_pad", want_r.zero, got_r.zero);
        cmp_field("plus_sign", want_r.plus, got_r.plus);
        cmp_field("space_sign", want_r.space, got_r.space);
        cmp_field("alt_form", want_r.alt, got_r.alt);
        cmp_field("has_dot", want_r.dot, got_r.dot);
        cmp_field("field_width", want_r.width, got_r.width);
        cmp_field("prec_value", want_r.prec, got_r.prec);
        cmp_field("conversion", want_r.conv, got_r.conv);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Called at a clock edge; returns at the edge where the item was taken.
  task automatic send_item(logic cmd, logic [7:0] c, logic signed [31:0] arg,
                           bit typed, dir_result_t want);
    dir_result_t pred;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {arg, c};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // ignored items (after done/error) don't count toward the run length
    if (cmd || (st_phase != pfs_pkg::PhDone && st_phase != pfs_pkg::PhErr)) live_items++;
    pred = predict_step(cmd, c, arg);
    directive_results_q.push_back(typed ? want : pred);
  endtask

  // First character of a directive carries the start command.
  task automatic send_ch(logic [7:0] c, logic signed [31:0] arg);
    send_item(new_directive, c, arg, 1'b0, '0);
    new_directive = 1'b0;
  endtask

  function automatic logic [7:0] rand_digit();
    return pfs_pkg::ChZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic signed [31:0] rand_star_arg();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return 32'(int'($urandom_range(0, 100)) - 50);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_digits(int lo, int hi);
    repeat ($urandom_range(lo, hi)) send_ch(rand_digit(), $urandom);
  endtask

  // A mostly well-formed directive with random content; some end on a bad
  // type, some never get one, some are followed by characters to ignore.
  task automatic send_directive();
    logic [7:0] c;
    int         k;
    new_directive = 1'b1;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0:       c = pfs_pkg::ChMinus;
        1:       c = pfs_pkg::ChZero;
        2:       c = pfs_pkg::ChPlus;
        3:       c = pfs_pkg::ChSpace;
        default: c = pfs_pkg::ChHash;
      endcase
      send_ch(c, $urandom);
    end
    case ($urandom_range(0, 9))
      0, 1, 2:       ;
      3, 4, 5, 6:    send_digits(1, 3);
      7, 8:          send_ch(pfs_pkg::ChStar, rand_star_arg());
      default:       send_digits(10, 12);   // long digit run, can overflow and saturate
    endcase
    if ($urandom_range(0, 1)) begin
      send_ch(pfs_pkg::ChDot, $urandom);
      case ($urandom_range(0, 9))
        0, 1:          ;
        2, 3, 4, 5, 6: send_digits(1, 3);
        7, 8:          send_ch(pfs_pkg::ChStar, rand_star_arg());
        default:       send_digits(10, 12);
      endcase
    end
    k = $urandom_range(0, 19);
    if (k < 17) begin
      case ($urandom_range(0, 8))
        0:       c = "c";
        1:       c = "s";
        2:       c = "p";
        3:       c = "d";
        4:       c = "i";
        5:       c = "u";
        6:       c = "x";
        7:       c = "X";
        default: c = "%";
      endcase
      send_ch(c, $urandom);
    end else if (k < 19) begin
      send_ch(8'($urandom_range(0, 255)), $urandom);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) send_ch(8'($urandom_range(0, 255)), $urandom);
    end
  endtask

  // Mix of directives and raw noise (random command bit, byte and argument).
  task automatic send_random_mix();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom,
                  1'b0, '0);
      end
    end else begin
      send_directive();
    end
  endtask

  task automatic wait_drained();
    while (directive_results_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic stim_row_t mk_row(logic cmd, logic [7:0] c, logic signed [31:0] arg,
                                       bit typed = 1'b0, dir_result_t want = '0);
    stim_row_t r;
    r.cmd = cmd;
    r.ch = c;
    r.arg = arg;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic dir_result_t mk_result(logic [1:0] status, logic consumed,
                                            logic [7:0] conv);
    dir_result_t r;
    r = '0;
    r.status = status;
    r.consumed = consumed;
    r.conv = conv;
    return r;
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed rows: bare type right after reset, NUL as a
    // type, and a character arriving after an error.
    directed_rows.push_back(mk_row(1'b0, "%", $urandom, 1'b1,
                                   mk_result(pfs_pkg::StDone, 1'b1, "%")));
    directed_rows.push_back(mk_row(1'b1, 8'h00, $urandom, 1'b1,
                                   mk_result(pfs_pkg::StErr, 1'b0, 8'h00)));
    directed_rows.push_back(mk_row(1'b0, "d", $urandom, 1'b1,
                                   mk_result(pfs_pkg::StErr, 1'b0, 8'h00)));
    // every flag, minus blocking zero, most negative star width, max star precision
    directed_rows.push_back(mk_row(1'b1, pfs_pkg::ChZero, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChMinus, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChZero, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChPlus, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChSpace, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChHash, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChStar, 32'sh8000_0000));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChDot, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChStar, 32'sh7FFF_FFFF));
    directed_rows.push_back(mk_row(1'b0, "X", $urandom));
    directed_rows.push_back(mk_row(1'b0, "d", $urandom));   // ignored after done
    // width digit overflow, then a negative star precision that drops the dot
    directed_rows.push_back(mk_row(1'b1, "9", $urandom));
    repeat (9) directed_rows.push_back(mk_row(1'b0, "9", $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChDot, $urandom));
    directed_rows.push_back(mk_row(1'b0, pfs_pkg::ChStar, -32'sd1));
    directed_rows.push_back(mk_row(1'b0, "s", $urandom));

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].arg,
                directed_rows[i].typed, directed_rows[i].want);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Long receiver hold-off while items keep coming: the block must stall.
    hold_req = 1'b1;
    gaps_on = 1'b0;
    repeat (8) send_directive();

    while (live_items < 780) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_mix();
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Final stretch at full rate on both sides.
    gaps_on = 1'b0;
    while (live_items < 920) send_random_mix();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("summary: %0d live items, %0d results checked", live_items, results_seen);
    $display("summary: %0d complete, %0d rejected, %0d with saturated width",
             done_seen, err_seen, sat_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
